[rtl/core/b3dch_pkg.sv]
// ----------------------------------------------------------------------------
// BLAKE3-style domain chained hash package
// Shared types, constants and functions of the hash unit.
// ----------------------------------------------------------------------------
package b3dch_pkg;

  localparam int unsigned Rounds     = 7;
  localparam int unsigned DomainMax  = 28;
  localparam int unsigned BlockBytes = 64;
  localparam logic [31:0] RootFlag   = 32'd8;
  localparam int unsigned AddrWidth  = 6;

  localparam logic [AddrWidth-1:0] AddrDom0   = 6'd0;
  localparam logic [AddrWidth-1:0] AddrDom1   = 6'd8;
  localparam logic [AddrWidth-1:0] AddrDom2   = 6'd16;
  localparam logic [AddrWidth-1:0] AddrDom3   = 6'd24;
  localparam logic [AddrWidth-1:0] AddrDomLen = 6'd32;
  localparam logic [AddrWidth-1:0] AddrDigLen = 6'd40;

  localparam logic [31:0] Iv [4] = '{32'h6A09E667, 32'hBB67AE85,
                                     32'h3C6EF372, 32'hA54FF53A};
  localparam logic [3:0] Perm [16] = '{4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4,
                                       4'd13, 4'd1, 4'd11, 4'd12, 4'd5, 4'd9,
                                       4'd14, 4'd15, 4'd8};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       start;
    logic [6:0] len;
    logic       root;
  } comp_req_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Half of a G function: one add pair, xor and rotate step.
  function automatic logic [127:0] half_g(input logic [127:0] abcd, input logic [31:0] m,
                                          input logic second);
    logic [31:0] a, b, c, d;
    a = abcd[31:0];
    b = abcd[63:32];
    c = abcd[95:64];
    d = abcd[127:96];
    a = a + b + m;
    d = rotr(d ^ a, second ? 8 : 16);
    c = c + d;
    b = rotr(b ^ c, second ? 7 : 12);
    half_g = {d, c, b, a};
  endfunction

endpackage

[rtl/core/blake3_domain_chained_hash_unit.sv]
// ----------------------------------------------------------------------------
// BLAKE3-style domain chained hash unit
// An item needing no compression is taken without a stall; one after a full block, or a last item,
// holds the input while a compression runs (start, the 7 rounds of column and diagonal steps, write
// back), twice for a last item after a full block. The digest is
// held in an output register; the next root compression
// waits until it is taken. Reset is synchronous, restores defaults and opens a message.
// ----------------------------------------------------------------------------
module blake3_domain_chained_hash_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // data_bytes[63:0], byte_count[67:64], zero pad
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [255:0] m_tdata,  // digest_0, digest_1, digest_2, digest_3
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [b3dch_pkg::AddrWidth-1:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] dom0, dom1, dom2;
  logic [31:0] dom3;
  logic [4:0]  domain_length;
  logic [5:0]  digest_length;

  b3dch_pkg::state_t state, state_next;
  logic [31:0] cv [8];
  logic [31:0] buffer [16];
  logic [6:0]  fill;
  logic        message_start;
  logic        pend_valid;
  logic [63:0] pend_data;
  logic [3:0]  pend_count;
  logic        pend_last;
  logic        comp_root;
  b3dch_pkg::comp_req_t req;
  logic        done;
  logic [31:0] cv_out [8];

  logic        accept;
  logic [3:0]  count;
  logic [31:0] dom_cv [8];
  logic [223:0] dom_flat;

  assign pready   = 1'b1;
  assign s_tready = (state == b3dch_pkg::ST_IDLE) && !pend_valid;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dom0 <= '0; dom1 <= '0; dom2 <= '0; dom3 <= '0;
      domain_length <= '0;
      digest_length <= 6'd32;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        b3dch_pkg::AddrDom0:   dom0 <= pwdata;
        b3dch_pkg::AddrDom1:   dom1 <= pwdata;
        b3dch_pkg::AddrDom2:   dom2 <= pwdata;
        b3dch_pkg::AddrDom3:   dom3 <= pwdata[31:0];
        b3dch_pkg::AddrDomLen: domain_length <= pwdata[4:0];
        b3dch_pkg::AddrDigLen: digest_length <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      b3dch_pkg::AddrDom0:   prdata = dom0;
      b3dch_pkg::AddrDom1:   prdata = dom1;
      b3dch_pkg::AddrDom2:   prdata = dom2;
      b3dch_pkg::AddrDom3:   prdata = {32'd0, dom3};
      b3dch_pkg::AddrDomLen: prdata = {59'd0, domain_length};
      b3dch_pkg::AddrDigLen: prdata = {58'd0, digest_length};
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    dom_flat = {dom3, dom2, dom1, dom0};
    for (int i = 0; i < 7; i++) begin
      for (int b = 0; b < 4; b++) begin
        dom_cv[i][8*b +: 8] = ((4 * i + b) < int'(domain_length) &&
                               (4 * i + b) < b3dch_pkg::DomainMax) ?
                              dom_flat[8 * (4 * i + b) +: 8] : 8'd0;
      end
    end
    dom_cv[7] = {27'd0, domain_length};
  end

  assign count = (!s_tlast || s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];

  b3dch_round_unit u_round (
    .clk(clk), .rst(rst), .req(req), .cv_in(cv), .msg_in(buffer),
    .done(done), .cv_out(cv_out)
  );

  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.len    = fill;
    req.root   = comp_root;
    unique case (state)
      b3dch_pkg::ST_IDLE: if (pend_valid && !(comp_root && m_tvalid)) begin
        state_next = b3dch_pkg::ST_COMP;
        req.start  = 1'b1;
      end
      b3dch_pkg::ST_COMP: if (done) begin
        state_next = b3dch_pkg::ST_IDLE;
      end
      b3dch_pkg::ST_OUT: if (!m_tvalid || m_tready) begin
        state_next = b3dch_pkg::ST_IDLE;
      end
      default: state_next = b3dch_pkg::ST_IDLE;
    endcase
  end

  // An accepted item needing a compression is held; a root one waits until the digest is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= b3dch_pkg::ST_IDLE;
      fill          <= '0;
      message_start <= 1'b1;
      pend_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
      comp_root     <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (req.start) pend_valid <= 1'b0;
      if (accept) begin
        logic [6:0] f;
        logic [31:0] lo_word;
        logic [31:0] hi_word;
        logic        put;
        f = message_start ? 7'd0 : fill;
        put = (count != 4'd0) && (f < 7'(b3dch_pkg::BlockBytes));
        lo_word = s_tdata[31:0] &
                  (count >= 4'd4 ? 32'hFFFFFFFF :
                   32'((33'd1 << (8 * count)) - 33'd1));
        hi_word = count == 4'd8 ? s_tdata[63:32] :
                  s_tdata[63:32] &
                  (count > 4'd4 ? 32'((33'd1 << (8 * (count - 4'd4))) - 33'd1) : 32'd0);
        if (message_start) begin
          for (int i = 0; i < 8; i++) cv[i] <= dom_cv[i];
        end
        for (int i = 0; i < 16; i++) begin
          if (put && 4'(i) == {f[5:3], 1'b0}) buffer[i] <= lo_word;
          else if (put && 4'(i) == {f[5:3], 1'b1}) buffer[i] <= hi_word;
          else if (message_start) buffer[i] <= '0;
        end
        message_start <= 1'b0;
        if (count != 4'd0 && f >= 7'(b3dch_pkg::BlockBytes)) begin
          pend_valid <= 1'b1;
          comp_root  <= 1'b0;
          fill       <= f;
        end else begin
          fill <= f + 7'(count);
          if (s_tlast) begin
            pend_valid <= 1'b1;
            comp_root  <= 1'b1;
          end
        end
        pend_data  <= s_tdata[63:0];
        pend_count <= count;
        pend_last  <= s_tlast;
      end
      if (done) begin
        logic [5:0] dig;
        logic [255:0] full;
        logic [31:0] held_lo;
        logic [31:0] held_hi;
        held_lo = pend_data[31:0] &
                  (pend_count >= 4'd4 ? 32'hFFFFFFFF :
                   32'((33'd1 << (8 * pend_count)) - 33'd1));
        held_hi = pend_count == 4'd8 ? pend_data[63:32] :
                  pend_data[63:32] &
                  (pend_count > 4'd4 ? 32'((33'd1 << (8 * (pend_count - 4'd4)))
                   - 33'd1) : 32'd0);
        for (int i = 0; i < 8; i++) cv[i] <= cv_out[i];
        // The held item goes into the fresh block after a full one.
        for (int i = 0; i < 16; i++) begin
          if (!comp_root && i == 0) buffer[i] <= held_lo;
          else if (!comp_root && i == 1) buffer[i] <= held_hi;
          else buffer[i] <= '0;
        end
        if (comp_root) begin
          dig = (digest_length > 6'd32) ? 6'd32 : digest_length;
          if (domain_length > 5'(b3dch_pkg::DomainMax)) dig = '0;
          for (int i = 0; i < 8; i++) full[32*i +: 32] = cv_out[i];
          for (int i = 0; i < 32; i++)
            m_tdata[8*i +: 8] <= (i < int'(dig)) ? full[8*i +: 8] : 8'd0;
          m_tvalid      <= 1'b1;
          fill          <= '0;
          message_start <= 1'b1;
        end else begin
          fill <= 7'(pend_count);
          if (pend_last) begin
            pend_valid <= 1'b1;
            comp_root  <= 1'b1;
          end
        end
      end
    end
  end

endmodule

[rtl/core/b3dch_round_unit.sv]
// ----------------------------------------------------------------------------
// Compression engine
// One shared stage of four half G functions, used twice a half round.
// ----------------------------------------------------------------------------
module b3dch_round_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  b3dch_pkg::comp_req_t req,
  input  logic [31:0]          cv_in  [8],
  input  logic [31:0]          msg_in [16],
  output logic                 done,
  output logic [31:0]          cv_out [8]
);

  logic [31:0] v [16];
  logic [31:0] m [16];
  logic        busy;
  logic [2:0]  round;
  logic [1:0]  phase;
  logic [31:0] v_next [16];
  logic [31:0] m_next [16];

  // phase: 0 column first half, 1 column second half, 2 diagonal first, 3 diagonal second
  always_comb begin
    logic [127:0] r;
    int unsigned ia, ib, ic, id, mi;
    v_next = v;
    m_next = m;
    for (int g = 0; g < 4; g++) begin
      if (!phase[1]) begin
        ia = g; ib = 4 + g; ic = 8 + g; id = 12 + g;
      end else begin
        ia = g; ib = 4 + ((g + 1) % 4); ic = 8 + ((g + 2) % 4); id = 12 + ((g + 3) % 4);
      end
      mi = (phase[1] ? 8 : 0) + 2 * g + (phase[0] ? 1 : 0);
      r = b3dch_pkg::half_g({v[id], v[ic], v[ib], v[ia]}, m[mi], phase[0]);
      v_next[ia] = r[31:0];
      v_next[ib] = r[63:32];
      v_next[ic] = r[95:64];
      v_next[id] = r[127:96];
    end
    if (phase == 2'd3) begin
      for (int i = 0; i < 16; i++) m_next[i] = m[b3dch_pkg::Perm[i]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      round <= '0;
      phase <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        round <= '0;
        phase <= '0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) begin
          round <= round + 3'd1;
          if (round == 3'(b3dch_pkg::Rounds - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      for (int i = 0; i < 8; i++) v[i] <= cv_in[i];
      for (int i = 0; i < 4; i++) v[8 + i] <= b3dch_pkg::Iv[i];
      v[12] <= '0;
      v[13] <= '0;
      v[14] <= {25'd0, req.len};
      v[15] <= req.root ? b3dch_pkg::RootFlag : 32'd0;
      m     <= msg_in;
    end else if (busy) begin
      v <= v_next;
      m <= m_next;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) cv_out[i] = v[i] ^ v[i + 8];
  end

endmodule

[rtl/core/b3dch_checker.sv]
// ----------------------------------------------------------------------------
// Port checker for the hash unit
// Checks handshake and result behaviour seen on the ports.
// ----------------------------------------------------------------------------
module b3dch_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic s_tlast,
  input logic m_tvalid,
  input logic m_tready,
  input logic [255:0] m_tdata,
  input logic pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result changed while stalled.");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped.");

  a_no_accept_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("Input accepted during compression.");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result valid after reset.");

endmodule

bind blake3_domain_chained_hash_unit b3dch_checker u_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
